@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the session supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define MSTS_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("msts assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define MSTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msts assertion failed");
`else
`define MSTS_ASSERT(label, cond)
`define MSTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/msts_pkg.sv @@
// Package with types, codes and constants of the session supervisor.
`default_nettype none

package msts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 3;
  localparam int KIND_W     = 3;
  localparam int KA_W       = 16;
  localparam int TIME_W     = 32;
  localparam int RK_W       = 2;
  localparam int LIMIT_W    = 8;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int KA_LIMIT_W = 27;

  localparam logic [KIND_W-1:0] KIND_ACCEPT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACTIVITY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CONNECT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd4;

  localparam logic [RK_W-1:0] RK_GRANT  = 2'd0;
  localparam logic [RK_W-1:0] RK_REFUSE = 2'd1;
  localparam logic [RK_W-1:0] RK_CLOSE  = 2'd2;
  localparam logic [RK_W-1:0] RK_DONE   = 2'd3;

  localparam logic REG_CLIENT_LIMIT    = 1'b0;
  localparam logic REG_CONNECT_TIMEOUT = 1'b1;

  localparam logic [KA_LIMIT_W-1:0] KA_SCALE_MS = 27'd1500;
  localparam logic [KA_LIMIT_W-1:0] KA_GRACE_MS = 27'd5000;
  localparam logic [TIME_W-1:0]     CTO_RESET   = 32'd10000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [KA_W-1:0]   ka_sec;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [RK_W-1:0]   result_kind;
    logic [SLOT_W-1:0] result_slot;
    logic              last;
  } out_item_t;

  // Direct command to the addressed cell
  typedef struct packed {
    logic              act;
    logic              conn;
    logic              close;
    logic [KA_W-1:0]   ka;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // Scan in progress, broadcast to all cells
  typedef struct packed {
    logic              accept;
    logic [TIME_W-1:0] now;
  } scan_t;

  // Per-cell status seen by the control
  typedef struct packed {
    logic tok;
    logic in_use;
    logic closing;
    logic auth;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/msts_cell.sv @@
// One session slot cell: slot state, timeout check and scan token stage.
`default_nettype none

module msts_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  msts_pkg::cmd_t              cmd,
  input  logic                        sel,
  input  msts_pkg::scan_t             scan,
  input  logic [msts_pkg::TIME_W-1:0] connect_timeout,
  input  logic                        tok_in,
  output logic                        tok_out,
  output logic                        hit,
  output msts_pkg::stat_t             stat
);

  logic                            tok;
  logic                            in_use;
  logic                            closing;
  logic                            auth;
  logic                            ka_on;
  logic [msts_pkg::TIME_W-1:0]     last_act;
  logic [msts_pkg::KA_LIMIT_W-1:0] ka_limit;

  logic [msts_pkg::TIME_W-1:0] idle;
  logic                        expire;
  logic                        claim;
  logic                        timeout;
  logic                        conn_ok;

  always_comb begin
    idle    = scan.now - last_act;
    expire  = auth ? (ka_on && (idle > msts_pkg::TIME_W'(ka_limit)))
                   : (idle > connect_timeout);
    claim   = tok && scan.accept && !in_use;
    timeout = tok && !scan.accept && in_use && !closing && expire;
    hit     = claim || timeout;
    tok_out = tok && !claim;
    conn_ok = sel && cmd.conn && in_use && !closing;
    stat    = '{tok: tok, in_use: in_use, closing: closing, auth: auth};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= 1'b0;
      in_use  <= 1'b0;
      closing <= 1'b0;
      auth    <= 1'b0;
      ka_on   <= 1'b0;
    end else begin
      tok <= tok_in;
      if (claim) begin
        in_use  <= 1'b1;
        closing <= 1'b0;
        auth    <= 1'b0;
        ka_on   <= 1'b0;
      end
      if (timeout) begin
        closing <= 1'b1;
      end
      if (conn_ok) begin
        if (auth) begin
          closing <= 1'b1;
        end else begin
          auth  <= 1'b1;
          ka_on <= (cmd.ka != '0);
        end
      end
      if (sel && cmd.close && in_use) begin
        in_use  <= 1'b0;
        closing <= 1'b0;
        auth    <= 1'b0;
        ka_on   <= 1'b0;
      end
    end
  end

  // Time stamp and keepalive limit carry no reset
  always_ff @(posedge clk) begin
    if (claim) begin
      last_act <= scan.now;
    end
    if (sel && cmd.act && in_use) begin
      last_act <= cmd.now;
    end
    if (conn_ok && !auth) begin
      ka_limit <= msts_pkg::KA_LIMIT_W'(cmd.ka) * msts_pkg::KA_SCALE_MS
                  + msts_pkg::KA_GRACE_MS;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mqtt_session_timeout_supervisor.sv @@
// Top level of the MQTT session supervisor: control, registers and the slot cell row.
// Activity, connect, close and unknown items answer the cycle after acceptance, busy low.
// Accept walks a token down the cells one slot per cycle and grants the first free cell;
// refusal at the limit answers the cycle after acceptance. A tick ends with the flush
// after the token walk; busy holds new items off until the final result.
// rst (synchronous) resets slots, count and registers; time stamps stay undefined till used.
`default_nettype none
`include "assert_macros.svh"

module mqtt_session_timeout_supervisor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  msts_pkg::in_item_t   item,
  output logic                 result_valid,
  output msts_pkg::out_item_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;

  // Configuration registers
  logic [msts_pkg::LIMIT_W-1:0] client_limit;
  logic [msts_pkg::TIME_W-1:0]  connect_timeout;

  // Control registers
  logic [msts_pkg::CNT_W-1:0]  in_use_count;
  msts_pkg::scan_t             scan;
  logic                        pend_v;
  logic [msts_pkg::SLOT_W-1:0] pend_slot;

  // Cell row signals
  msts_pkg::cmd_t                cmd;
  logic [msts_pkg::SLOT_COUNT-1:0] sel;
  logic [msts_pkg::SLOT_COUNT-1:0] tok_in;
  logic [msts_pkg::SLOT_COUNT-1:0] tok_out;
  logic [msts_pkg::SLOT_COUNT-1:0] hits;
  msts_pkg::stat_t               stats [msts_pkg::SLOT_COUNT];
  logic [msts_pkg::SLOT_COUNT-1:0] tok_vec;
  logic [msts_pkg::SLOT_COUNT-1:0] in_use_vec;
  logic [msts_pkg::SLOT_COUNT-1:0] closing_vec;
  logic [msts_pkg::SLOT_COUNT-1:0] auth_vec;

  logic                         take;
  logic [msts_pkg::LIMIT_W-1:0] eff_limit;
  logic                         can_admit;
  logic                         inject;
  logic                         sel_valid;
  logic                         dup;
  logic                         hit_any;
  logic [msts_pkg::SLOT_W-1:0]  hit_slot;
  logic                         tok_last;

  assign busy   = (state != ST_IDLE);
  assign take   = start && !busy;
  assign pready = 1'b1;

  // Register reads decode on the word address bit only
  assign prdata = paddr[2] ? connect_timeout : 32'(client_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      client_limit    <= '0;
      connect_timeout <= msts_pkg::CTO_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == msts_pkg::REG_CONNECT_TIMEOUT) begin
        connect_timeout <= pwdata;
      end else if (paddr[2] == msts_pkg::REG_CLIENT_LIMIT) begin
        client_limit <= pwdata[msts_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Zero or a limit above the slot count admits every slot
  always_comb begin
    if (client_limit == '0 || client_limit > msts_pkg::LIMIT_W'(msts_pkg::SLOT_COUNT)) begin
      eff_limit = msts_pkg::LIMIT_W'(msts_pkg::SLOT_COUNT);
    end else begin
      eff_limit = client_limit;
    end
    can_admit = msts_pkg::LIMIT_W'(in_use_count) < eff_limit;
  end

  // Direct commands reach the addressed cell at the accepting edge
  always_comb begin
    cmd.act   = take && (item.kind == msts_pkg::KIND_ACTIVITY);
    cmd.conn  = take && (item.kind == msts_pkg::KIND_CONNECT);
    cmd.close = take && (item.kind == msts_pkg::KIND_CLOSE);
    cmd.ka    = item.ka_sec;
    cmd.now   = item.now_ms;
    inject    = take && (((item.kind == msts_pkg::KIND_ACCEPT) && can_admit)
                         || (item.kind == msts_pkg::KIND_TICK));
  end

  // Cell row: the scan token enters at slot 0 and moves one cell per cycle
  for (genvar i = 0; i < msts_pkg::SLOT_COUNT; i++) begin : g_cell
    assign sel[i]         = (item.slot == msts_pkg::SLOT_W'(i));
    assign tok_vec[i]     = stats[i].tok;
    assign in_use_vec[i]  = stats[i].in_use;
    assign closing_vec[i] = stats[i].closing;
    assign auth_vec[i]    = stats[i].auth;
    if (i == 0) begin : g_head
      assign tok_in[i] = inject;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end

    msts_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .cmd             (cmd),
      .sel             (sel[i]),
      .scan            (scan),
      .connect_timeout (connect_timeout),
      .tok_in          (tok_in[i]),
      .tok_out         (tok_out[i]),
      .hit             (hits[i]),
      .stat            (stats[i])
    );
  end

  assign tok_last  = tok_out[msts_pkg::SLOT_COUNT-1];
  assign sel_valid = |(sel & in_use_vec);
  assign dup       = |(sel & in_use_vec & ~closing_vec & auth_vec);
  assign hit_any   = |hits;

  // At most one cell holds the token, so OR the indexes of the hitting cells
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < msts_pkg::SLOT_COUNT; i++) begin
      if (hits[i]) begin
        hit_slot = hit_slot | msts_pkg::SLOT_W'(i);
      end
    end
  end

  // Control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      pend_v       <= 1'b0;
      in_use_count <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            result.result_slot <= '0;
            result.last        <= 1'b1;
            result.result_kind <= msts_pkg::RK_DONE;
            case (item.kind)
              msts_pkg::KIND_ACCEPT: begin
                if (can_admit) begin
                  state       <= ST_SCAN;
                  scan.accept <= 1'b1;
                  scan.now    <= item.now_ms;
                end else begin
                  result_valid       <= 1'b1;
                  result.result_kind <= msts_pkg::RK_REFUSE;
                end
              end
              msts_pkg::KIND_TICK: begin
                state       <= ST_SCAN;
                scan.accept <= 1'b0;
                scan.now    <= item.now_ms;
              end
              msts_pkg::KIND_CONNECT: begin
                result_valid <= 1'b1;
                if (dup) begin
                  result.result_kind <= msts_pkg::RK_CLOSE;
                  result.result_slot <= item.slot;
                end
              end
              msts_pkg::KIND_CLOSE: begin
                result_valid <= 1'b1;
                if (sel_valid) begin
                  in_use_count <= in_use_count - 1'b1;
                end
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit_any && scan.accept) begin
            // First free cell claimed: grant it and end the scan
            result_valid       <= 1'b1;
            result.result_kind <= msts_pkg::RK_GRANT;
            result.result_slot <= hit_slot;
            result.last        <= 1'b1;
            in_use_count       <= in_use_count + 1'b1;
            state              <= ST_IDLE;
          end else begin
            // Hold each close request in the pending register so the final one can carry last
            if (hit_any) begin
              if (pend_v) begin
                result_valid       <= 1'b1;
                result.result_kind <= msts_pkg::RK_CLOSE;
                result.result_slot <= pend_slot;
                result.last        <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_slot <= hit_slot;
            end
            if (tok_last) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          result_valid <= 1'b1;
          result.last  <= 1'b1;
          if (scan.accept) begin
            result.result_kind <= msts_pkg::RK_REFUSE;
            result.result_slot <= '0;
          end else if (pend_v) begin
            result.result_kind <= msts_pkg::RK_CLOSE;
            result.result_slot <= pend_slot;
          end else begin
            result.result_kind <= msts_pkg::RK_DONE;
            result.result_slot <= '0;
          end
          pend_v <= 1'b0;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Only one cell may hold the scan token
  `MSTS_ASSERT(a_tok_onehot, $onehot0(tok_vec))
  // The admitted count tracks the slots in use
  `MSTS_ASSERT(a_count_match, in_use_count == msts_pkg::CNT_W'($countones(in_use_vec)))
  // A closing slot is always in use
  `MSTS_ASSERT(a_closing_in_use, (closing_vec & ~in_use_vec) == '0)
  // A timeout found during a tick scan is held for reporting
  `MSTS_ASSERT_NEXT(a_tick_pend, (state == ST_SCAN) && !scan.accept && hit_any, pend_v)

endmodule

`default_nettype wire
